// ===== sv/isms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isms_pkg: shared types and constants for the interval set merge table
// Result status codes, cell command codes and the flag group passed between
// neighboring cells.
// ----------------------------------------------------------------------------
package isms_pkg;

	// Fixed field widths of the item ports.
	localparam int PORT_VALUE_W = 48;
	localparam int PORT_ENTRY_W = 9;
	localparam int PORT_COVER_W = 49;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_ROTATE,
		OP_INSERT,
		OP_MERGE,
		OP_SHIFT
	} cell_op_t;

	// Flags a cell hands to its right-hand neighbor.
	typedef struct packed {
		logic lower;
		logic touch;
	} cell_flags_t;

endpackage

// ===== sv/isms_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isms_cell: one table entry of the range chain
// Holds one range and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
module isms_cell #(
	parameter int VALUE_WIDTH = 48,
	parameter int CNT_W = 9,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  isms_pkg::cell_op_t       op,
	input  logic [CNT_W-1:0]         count,
	input  logic [VALUE_WIDTH-1:0]   key_lo,
	input  logic [VALUE_WIDTH-1:0]   key_hi,
	input  logic [VALUE_WIDTH-1:0]   mrg_lo,
	input  logic [VALUE_WIDTH-1:0]   mrg_hi,
	input  logic [VALUE_WIDTH-1:0]   left_lo,
	input  logic [VALUE_WIDTH-1:0]   left_hi,
	input  logic [VALUE_WIDTH-1:0]   right_lo,
	input  logic [VALUE_WIDTH-1:0]   right_hi,
	input  isms_pkg::cell_flags_t    left_flags,
	output isms_pkg::cell_flags_t    flags,
	output logic [VALUE_WIDTH-1:0]   lo,
	output logic [VALUE_WIDTH-1:0]   hi
);

	logic [VALUE_WIDTH-1:0] lo_q;
	logic [VALUE_WIDTH-1:0] hi_q;
	logic                   mark_q;
	logic                   occupied;
	logic                   first;
	logic [VALUE_WIDTH:0]   hi_p1;
	logic [VALUE_WIDTH:0]   key_hi_p1;

	assign occupied  = CNT_W'(IDX) < count;
	assign hi_p1     = {1'b0, hi_q} + 1'b1;
	assign key_hi_p1 = {1'b0, key_hi} + 1'b1;

	// lower: this range ends more than one below the key
	// touch: this range overlaps or borders the key
	assign flags.lower = occupied && (hi_p1 < {1'b0, key_lo});
	assign flags.touch = occupied && ({1'b0, key_lo} <= hi_p1) &&
		({1'b0, lo_q} <= key_hi_p1);
	assign first = flags.touch && !left_flags.touch;

	assign lo = lo_q;
	assign hi = hi_q;

	always_ff @(posedge clk) begin
		case (op)
			isms_pkg::OP_ROTATE: begin
				lo_q <= right_lo;
				hi_q <= right_hi;
			end
			isms_pkg::OP_INSERT: begin
				if (!flags.lower) begin
					if (left_flags.lower) begin
						lo_q <= key_lo;
						hi_q <= key_hi;
					end else begin
						lo_q <= left_lo;
						hi_q <= left_hi;
					end
				end
			end
			isms_pkg::OP_MERGE: begin
				if (first) begin
					lo_q <= mrg_lo;
					hi_q <= mrg_hi;
				end
			end
			isms_pkg::OP_SHIFT: begin
				if (mark_q) begin
					lo_q <= right_lo;
					hi_q <= right_hi;
				end
			end
			default: begin
			end
		endcase
	end

	// Mark every cell past the merged one; those close up the gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else if (op == isms_pkg::OP_MERGE) begin
			mark_q <= !flags.lower && !first;
		end
	end

endmodule

// ===== sv/isms_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isms_ctrl: sequencer for the range chain
// Scans the rotating chain at its head, decides insert or merge, steps the
// close-up shifts, keeps count and coverage, and holds the result register.
// ----------------------------------------------------------------------------
module isms_ctrl #(
	parameter int VALUE_WIDTH = 48,
	parameter int MAX_RANGES = 256,
	parameter int CNT_W = 9,
	parameter int POS_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [VALUE_WIDTH-1:0] lo_in,
	input  logic [VALUE_WIDTH-1:0] hi_in,
	input  logic [VALUE_WIDTH-1:0] val_in,
	output logic                   out_valid,
	input  logic                   out_stall,
	output isms_pkg::status_t      status_o,
	output logic                   found_o,
	output logic [CNT_W-1:0]       entry_o,
	output logic [VALUE_WIDTH:0]   cover_o,
	output isms_pkg::cell_op_t     op,
	output logic [CNT_W-1:0]       count,
	output logic [VALUE_WIDTH-1:0] key_lo,
	output logic [VALUE_WIDTH-1:0] key_hi,
	output logic [VALUE_WIDTH-1:0] mrg_lo,
	output logic [VALUE_WIDTH-1:0] mrg_hi,
	input  logic [VALUE_WIDTH-1:0] head_lo,
	input  logic [VALUE_WIDTH-1:0] head_hi
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_SHIFT,
		S_SUM,
		S_RESP
	} state_t;

	state_t                 state_q;
	logic                   query_q;
	logic [VALUE_WIDTH-1:0] key_lo_q;
	logic [VALUE_WIDTH-1:0] key_hi_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [VALUE_WIDTH-1:0] mrg_lo_q;
	logic [VALUE_WIDTH-1:0] mrg_hi_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       hits_q;
	logic [CNT_W-1:0]       shift_q;
	logic [CNT_W-1:0]       count_q;
	logic [VALUE_WIDTH:0]   sum_q;
	logic [VALUE_WIDTH:0]   tlen_q;
	logic [VALUE_WIDTH:0]   len_q;
	logic                   found_q;
	isms_pkg::status_t      status_q;

	logic                   out_valid_q;
	isms_pkg::status_t      status_o_q;
	logic                   found_o_q;
	logic [CNT_W-1:0]       entry_o_q;
	logic [VALUE_WIDTH:0]   cover_o_q;

	logic                   head_live;
	logic                   head_touch;
	logic                   head_hit;
	logic [VALUE_WIDTH:0]   head_hi_p1;
	logic [VALUE_WIDTH:0]   key_hi_p1;
	logic                   full;
	logic                   out_free;
	logic                   resp_go;

	assign head_live  = CNT_W'(pos_q) < count_q;
	assign head_hi_p1 = {1'b0, head_hi} + 1'b1;
	assign key_hi_p1  = {1'b0, key_hi_q} + 1'b1;
	assign head_touch = head_live && ({1'b0, key_lo_q} <= head_hi_p1) &&
		({1'b0, head_lo} <= key_hi_p1);
	assign head_hit   = head_live && query_q && (val_q >= head_lo) && (val_q <= head_hi);
	assign full       = (hits_q == '0) && (count_q == CNT_W'(MAX_RANGES));
	assign out_free   = !out_valid_q || !out_stall;
	assign resp_go    = (state_q == S_RESP) && out_free;

	always_comb begin
		case (state_q)
			S_SCAN:  op = isms_pkg::OP_ROTATE;
			S_APPLY: begin
				if (full) begin
					op = isms_pkg::OP_HOLD;
				end else if (hits_q == '0) begin
					op = isms_pkg::OP_INSERT;
				end else begin
					op = isms_pkg::OP_MERGE;
				end
			end
			S_SHIFT: op = isms_pkg::OP_SHIFT;
			default: op = isms_pkg::OP_HOLD;
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign status_o  = status_o_q;
	assign found_o   = found_o_q;
	assign entry_o   = entry_o_q;
	assign cover_o   = cover_o_q;
	assign count     = count_q;
	assign key_lo    = key_lo_q;
	assign key_hi    = key_hi_q;
	assign mrg_lo    = mrg_lo_q;
	assign mrg_hi    = mrg_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			query_q     <= 1'b0;
			key_lo_q    <= '0;
			key_hi_q    <= '0;
			val_q       <= '0;
			mrg_lo_q    <= '0;
			mrg_hi_q    <= '0;
			pos_q       <= '0;
			hits_q      <= '0;
			shift_q     <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			tlen_q      <= '0;
			len_q       <= '0;
			found_q     <= 1'b0;
			status_q    <= isms_pkg::ST_OK;
			out_valid_q <= 1'b0;
			status_o_q  <= isms_pkg::ST_OK;
			found_o_q   <= 1'b0;
			entry_o_q   <= '0;
			cover_o_q   <= '0;
		end else begin
			if (resp_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						query_q  <= opcode;
						key_lo_q <= lo_in;
						key_hi_q <= hi_in;
						val_q    <= val_in;
						mrg_lo_q <= lo_in;
						mrg_hi_q <= hi_in;
						pos_q    <= '0;
						hits_q   <= '0;
						tlen_q   <= '0;
						found_q  <= 1'b0;
						status_q <= (!opcode && (lo_in > hi_in)) ?
							isms_pkg::ST_REJECT : isms_pkg::ST_OK;
						if (!opcode && (lo_in > hi_in)) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// accumulate over the range now at the head of the chain
					if (head_touch) begin
						hits_q <= hits_q + 1'b1;
						tlen_q <= tlen_q + ({1'b0, head_hi} - {1'b0, head_lo} + 1'b1);
						if (head_lo < mrg_lo_q) begin
							mrg_lo_q <= head_lo;
						end
						if (head_hi > mrg_hi_q) begin
							mrg_hi_q <= head_hi;
						end
					end
					if (head_hit) begin
						found_q <= 1'b1;
					end
					pos_q <= pos_q + 1'b1;
					if (pos_q == POS_W'(MAX_RANGES - 1)) begin
						state_q <= query_q ? S_RESP : S_APPLY;
					end
				end
				S_APPLY: begin
					if (full) begin
						status_q <= isms_pkg::ST_FULL;
						state_q  <= S_RESP;
					end else if (hits_q == '0) begin
						count_q <= count_q + 1'b1;
						len_q   <= {1'b0, key_hi_q} - {1'b0, key_lo_q} + 1'b1;
						state_q <= S_SUM;
					end else begin
						count_q <= count_q - hits_q + 1'b1;
						sum_q   <= sum_q - tlen_q;
						len_q   <= {1'b0, mrg_hi_q} - {1'b0, mrg_lo_q} + 1'b1;
						shift_q <= hits_q - 1'b1;
						state_q <= (hits_q == CNT_W'(1)) ? S_SUM : S_SHIFT;
					end
				end
				S_SHIFT: begin
					// close the gap left by absorbed ranges, one place a cycle
					shift_q <= shift_q - 1'b1;
					if (shift_q == CNT_W'(1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q   <= sum_q + len_q;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						status_o_q  <= status_q;
						found_o_q   <= found_q;
						entry_o_q   <= count_q;
						cover_o_q   <= sum_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/interval_set_merge_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_merge_table_core: sorted table of disjoint ranges
// Inserts ranges with merging of overlapping or bordering entries and answers
// membership queries, over a chain of range cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): opcode 0 inserts [range_start,
//   range_end], opcode 1 asks whether query_value lies in a stored range.
//   Output channel (out_valid / out_stall): one result item per input item,
//   with status, found, entry_total and covered_total.
// Operation:
//   The ranges sit in a chain of MAX_RANGES cells. Every item first rotates
//   the whole chain once past its head, where touching ranges, the merged
//   bounds and membership are gathered. An insert then places or merges
//   the range, shifts the chain once per absorbed range beyond the first
//   to close it up, and then updates coverage. A query answers once the
//   rotation is done, as does an insert into a full table; a rejected
//   insert skips the rotation. The next item is taken only after the
//   result is registered, so one item is in work at a time.
// Reset and stall:
//   Reset empties the table and clears the counts. A finished result waits
//   in the output register while the next item is taken and worked on; the
//   sequencer holds a further result until the register frees up.
// ----------------------------------------------------------------------------
module interval_set_merge_table_core #(
	parameter int MAX_RANGES = 256,
	parameter int VALUE_WIDTH = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic [isms_pkg::PORT_VALUE_W-1:0]     range_start,
	input  logic [isms_pkg::PORT_VALUE_W-1:0]     range_end,
	input  logic [isms_pkg::PORT_VALUE_W-1:0]     query_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic                                  found,
	output logic [isms_pkg::PORT_ENTRY_W-1:0]     entry_total,
	output logic [isms_pkg::PORT_COVER_W-1:0]     covered_total
);

	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam int POS_W = $clog2(MAX_RANGES);
	localparam int PV_W  = isms_pkg::PORT_VALUE_W;
	localparam int PE_W  = isms_pkg::PORT_ENTRY_W;
	localparam int PC_W  = isms_pkg::PORT_COVER_W;

	// bring port values to the table width (values are taken modulo 2^width)
	logic [VALUE_WIDTH+PV_W-1:0]  start_ext;
	logic [VALUE_WIDTH+PV_W-1:0]  end_ext;
	logic [VALUE_WIDTH+PV_W-1:0]  query_ext;
	logic [CNT_W+PE_W-1:0]        entry_ext;
	logic [VALUE_WIDTH+PC_W:0]    cover_ext;

	isms_pkg::cell_op_t           op;
	isms_pkg::status_t            status_o;
	logic [CNT_W-1:0]             count;
	logic [CNT_W-1:0]             entry_o;
	logic [VALUE_WIDTH:0]         cover_o;
	logic [VALUE_WIDTH-1:0]       key_lo;
	logic [VALUE_WIDTH-1:0]       key_hi;
	logic [VALUE_WIDTH-1:0]       mrg_lo;
	logic [VALUE_WIDTH-1:0]       mrg_hi;

	logic [VALUE_WIDTH-1:0]       cell_lo [MAX_RANGES];
	logic [VALUE_WIDTH-1:0]       cell_hi [MAX_RANGES];
	isms_pkg::cell_flags_t        cell_flags [MAX_RANGES];

	assign start_ext = (VALUE_WIDTH + PV_W)'(range_start);
	assign end_ext   = (VALUE_WIDTH + PV_W)'(range_end);
	assign query_ext = (VALUE_WIDTH + PV_W)'(query_value);

	isms_ctrl #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_RANGES  (MAX_RANGES),
		.CNT_W       (CNT_W),
		.POS_W       (POS_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.lo_in     (start_ext[VALUE_WIDTH-1:0]),
		.hi_in     (end_ext[VALUE_WIDTH-1:0]),
		.val_in    (query_ext[VALUE_WIDTH-1:0]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status_o  (status_o),
		.found_o   (found),
		.entry_o   (entry_o),
		.cover_o   (cover_o),
		.op        (op),
		.count     (count),
		.key_lo    (key_lo),
		.key_hi    (key_hi),
		.mrg_lo    (mrg_lo),
		.mrg_hi    (mrg_hi),
		.head_lo   (cell_lo[0]),
		.head_hi   (cell_hi[0])
	);

	// Chain of cells: each takes from its right neighbor when rotating or
	// shifting, and from its left neighbor when an insert opens a slot.
	// The last cell wraps to the head so a full rotation restores the table.
	for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
		localparam int LEFT  = (k == 0) ? MAX_RANGES - 1 : k - 1;
		localparam int RIGHT = (k == MAX_RANGES - 1) ? 0 : k + 1;

		isms_pkg::cell_flags_t left_flags;

		if (k == 0) begin : g_head
			// the head always takes the new range when it is not below it
			assign left_flags = '{lower: 1'b1, touch: 1'b0};
		end else begin : g_body
			assign left_flags = cell_flags[LEFT];
		end

		isms_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.CNT_W       (CNT_W),
			.IDX         (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.count      (count),
			.key_lo     (key_lo),
			.key_hi     (key_hi),
			.mrg_lo     (mrg_lo),
			.mrg_hi     (mrg_hi),
			.left_lo    (cell_lo[LEFT]),
			.left_hi    (cell_hi[LEFT]),
			.right_lo   (cell_lo[RIGHT]),
			.right_hi   (cell_hi[RIGHT]),
			.left_flags (left_flags),
			.flags      (cell_flags[k]),
			.lo         (cell_lo[k]),
			.hi         (cell_hi[k])
		);
	end

	// result fields at their port widths
	assign entry_ext     = (CNT_W + PE_W)'(entry_o);
	assign cover_ext     = (VALUE_WIDTH + PC_W + 1)'(cover_o);
	assign status        = status_o;
	assign entry_total   = entry_ext[PE_W-1:0];
	assign covered_total = cover_ext[PC_W-1:0];

endmodule

// ===== sv/isms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isms_port_checks: port checks for the interval set merge table
// Watches the input and result channels of the top level over time.
// ----------------------------------------------------------------------------
module isms_port_checks (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [1:0]                          status,
	input logic                                found,
	input logic [isms_pkg::PORT_ENTRY_W-1:0]   entry_total,
	input logic [isms_pkg::PORT_COVER_W-1:0]   covered_total
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(found) &&
		$stable(entry_total) && $stable(covered_total))
		else $error("result changed while stalled");

	// only the defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == isms_pkg::ST_OK) || (status == isms_pkg::ST_REJECT) ||
		(status == isms_pkg::ST_FULL))
		else $error("undefined status code");

	// found comes only from a query, which always has status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == isms_pkg::ST_OK)
		else $error("found set on a failed item");

	// an empty table covers nothing
	a_empty_cover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entry_total == '0) |-> covered_total == '0)
		else $error("coverage without entries");

	// a taken item leaves the input side busy in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken back to back");

endmodule

bind interval_set_merge_table_core isms_port_checks u_isms_port_checks (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.found         (found),
	.entry_total   (entry_total),
	.covered_total (covered_total)
);
